FILE: sv/qse_pkg.sv
// qse_pkg: shared types, codes and helpers of the quadrature sub-step estimator.
// No dependencies; imported by every module of the block but qse_checker.
`timescale 1ns / 1ps
package qse_pkg;

   localparam int unsigned DataWidth   = 32;
   localparam int unsigned CsrWidth    = 8;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned DivNumWidth = 64;

   localparam logic [DataWidth-1:0] SubstepHalf = 32'd32;
   localparam logic [DataWidth-1:0] SignBit     = 32'h8000_0000;
   localparam logic [DataWidth-1:0] StepMask    = 32'hFFFF_FF00;
   localparam logic [17:0]          UsPerSecK   = 18'd62500;

   localparam logic [CsrIdxWidth-1:0] CSR_CLOCKS_PER_US = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_PHASE1        = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_PHASE2        = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_PHASE3        = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_IDLE_LIMIT    = 3'd4;

   localparam logic [CsrWidth-1:0] RstClocksPerUs = 8'd125;
   localparam logic [CsrWidth-1:0] RstPhase1      = 8'd64;
   localparam logic [CsrWidth-1:0] RstPhase2      = 8'd128;
   localparam logic [CsrWidth-1:0] RstPhase3      = 8'd192;
   localparam logic [CsrWidth-1:0] RstIdleLimit   = 8'd3;

   typedef enum logic [4:0] {
      S_IDLE, S_QS, S_QW, S_POUT, S_CHK, S_FSS, S_FSW, S_TR, S_HIS, S_HIW,
      S_LOS, S_LOW, S_CLAMP, S_MUL, S_POS, S_FIN, S_OUT
   } qse_state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_CAPTURE, OP_PRIME, OP_TRANS, OP_WR_FS, OP_TRUPD, OP_WR_HI,
      OP_WR_LO, OP_CLAMP, OP_MUL, OP_POS, OP_FIN, OP_OUTLOAD
   } qse_op_type;

   typedef enum logic [1:0] {
      SEL_Q, SEL_FS, SEL_HI, SEL_LO
   } qse_sel_type;

   typedef struct packed {
      qse_op_type  op;
      logic        div_start;
      qse_sel_type div_sel;
   } qse_cmd_type;

   typedef struct packed {
      logic div_done;
      logic primed;
      logic changed;
      logic stopped;
   } qse_status_type;

   // first sub-step of a step: upper bits from the step count, calibrated phase offset in the low byte
   function automatic logic [DataWidth-1:0] step_start(
      input logic [DataWidth-1:0] step,
      input logic [CsrWidth-1:0]  p1,
      input logic [CsrWidth-1:0]  p2,
      input logic [CsrWidth-1:0]  p3
   );
      logic [CsrWidth-1:0] off;
      case (step[1:0])
         2'd1: off = p1;
         2'd2: off = p2;
         2'd3: off = p3;
         default: off = '0;
      endcase
      return ((step << 6) & StepMask) | {{(DataWidth-CsrWidth){1'b0}}, off};
   endfunction

endpackage

FILE: sv/quadrature_substep_estimator.sv
// Channel  Ports                                                  Direction
// req      req_valid/ready, step_count, transition_cycles, sample_us   in
// rsp      rsp_valid/ready, position, speed, speed_fine, is_stopped    out
// csr      csr_we, csr_index, csr_wdata                                in
//
// One item at a time. The first item after reset only primes the estimator; later items
// compute the two bound slopes unless the encoder stays stopped, plus a transition
// slope on a step change while running. A single divider is shared by the time
// quotient and up to three slopes.
// Reset is synchronous and restores the calibration registers to their defaults.
// req_ready is low from acceptance until the result item is taken.
`timescale 1ns / 1ps
module quadrature_substep_estimator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [qse_pkg::DataWidth-1:0]        req_step_count,
   input  logic signed [qse_pkg::DataWidth-1:0] req_transition_cycles,
   input  logic [qse_pkg::DataWidth-1:0]        req_sample_us,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [qse_pkg::DataWidth-1:0]        rsp_position,
   output logic signed [qse_pkg::DataWidth-1:0] rsp_speed,
   output logic signed [qse_pkg::DataWidth-1:0] rsp_speed_fine,
   output logic                                 rsp_is_stopped,
   input  logic                                 csr_we,
   input  logic [qse_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [qse_pkg::CsrWidth-1:0]         csr_wdata
);
   import qse_pkg::*;

   qse_cmd_type    cmd;
   qse_status_type status;

   qse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   qse_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_step_count        (req_step_count),
      .req_transition_cycles (req_transition_cycles),
      .req_sample_us         (req_sample_us),
      .rsp_position          (rsp_position),
      .rsp_speed             (rsp_speed),
      .rsp_speed_fine        (rsp_speed_fine),
      .rsp_is_stopped        (rsp_is_stopped)
   );

endmodule

FILE: sv/qse_div.sv
// qse_div: iterative restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on qse_pkg.
`timescale 1ns / 1ps
module qse_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [qse_pkg::DivNumWidth-1:0]    num,
   input  logic [qse_pkg::DataWidth-1:0]      den,
   output logic                               done,
   output logic [qse_pkg::DivNumWidth-1:0]    quo
);
   import qse_pkg::*;

   localparam int unsigned CntWidth = $clog2(DivNumWidth);

   logic [DivNumWidth-1:0] quo_ff, quo_in;
   logic [DataWidth-1:0]   rem_ff, rem_in, den_ff;
   logic [CntWidth-1:0]    cnt_ff;
   logic                   busy_ff, done_ff;
   logic [DataWidth:0]     shifted;
   logic [DataWidth+1:0]   diff;
   logic                   ge;

   assign shifted = {rem_ff, quo_ff[DivNumWidth-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};
   assign ge      = ~diff[DataWidth+1];
   assign rem_in  = ge ? diff[DataWidth-1:0] : shifted[DataWidth-1:0];
   assign quo_in  = {quo_ff[DivNumWidth-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CntWidth'(DivNumWidth - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

FILE: sv/qse_dp.sv
// qse_dp: datapath of the estimator: config registers, estimator state, slopes, clamps.
// Depends on qse_pkg and qse_div.
`timescale 1ns / 1ps
module qse_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  qse_pkg::qse_cmd_type                cmd,
   output qse_pkg::qse_status_type             status,
   input  logic                                csr_we,
   input  logic [qse_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [qse_pkg::CsrWidth-1:0]        csr_wdata,
   input  logic [qse_pkg::DataWidth-1:0]       req_step_count,
   input  logic signed [qse_pkg::DataWidth-1:0] req_transition_cycles,
   input  logic [qse_pkg::DataWidth-1:0]       req_sample_us,
   output logic [qse_pkg::DataWidth-1:0]       rsp_position,
   output logic signed [qse_pkg::DataWidth-1:0] rsp_speed,
   output logic signed [qse_pkg::DataWidth-1:0] rsp_speed_fine,
   output logic                                rsp_is_stopped
);
   import qse_pkg::*;

   // configuration
   logic [CsrWidth-1:0] cpu_ff, ph1_ff, ph2_ff, ph3_ff, idle_lim_ff;

   // estimator state
   logic                 primed_ff, stopped_ff;
   logic [CsrWidth-1:0]  idle_ff;
   logic [DataWidth-1:0] prev_step_ff, last_sample_ff, last_trans_us_ff, last_trans_pos_ff;
   logic [DataWidth-1:0] last_low_ff, last_high_ff, fine_ff, sec_ff, pos_est_ff;

   // per-item working registers
   logic [DataWidth-1:0] step_ff, now_ff, mag13_ff, trans_ff, shi_ff, slo_ff, pprod_ff;
   logic                 fwd_ff, neg_ff, dzero_ff;
   logic [DataWidth-1:0] out_pos_ff, out_sec_ff, out_fine_ff;
   logic                 out_stop_ff;

   logic [DataWidth-1:0]   mag, mag13_in, low, high, tpos, qres, sres, trans_in;
   logic [DataWidth-1:0]   d_sel, dt_sel, d_abs, dt_abs;
   logic [DivNumWidth-1:0] div_num;
   logic [DataWidth-1:0]   div_den;
   logic [DivNumWidth-1:0] div_quo;
   logic                   div_done, changed, br, stop_now;
   logic [CsrWidth-1:0]    idle_in;
   logic [DataWidth-1:0]   f1, f2, pos_raw, pos_in, lt_minus_ls;
   logic signed [49:0]     psec;
   logic signed [64:0]     ppos;

   always_ff @(posedge clock) begin
      if (reset) begin
         cpu_ff      <= RstClocksPerUs;
         ph1_ff      <= RstPhase1;
         ph2_ff      <= RstPhase2;
         ph3_ff      <= RstPhase3;
         idle_lim_ff <= RstIdleLimit;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CLOCKS_PER_US: cpu_ff      <= csr_wdata;
            CSR_PHASE1:        ph1_ff      <= csr_wdata;
            CSR_PHASE2:        ph2_ff      <= csr_wdata;
            CSR_PHASE3:        ph3_ff      <= csr_wdata;
            CSR_IDLE_LIMIT:    idle_lim_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // transition magnitude: negative word means forward
   assign mag      = req_transition_cycles[DataWidth-1] ? (32'd0 - req_transition_cycles)
                                                        : (SignBit - req_transition_cycles);
   assign mag13_in = (mag << 3) + (mag << 2) + mag;

   assign low     = step_start(step_ff, ph1_ff, ph2_ff, ph3_ff);
   assign high    = step_start(step_ff + 32'd1, ph1_ff, ph2_ff, ph3_ff);
   assign tpos    = fwd_ff ? low : high;
   assign changed = (step_ff != prev_step_ff);

   assign lt_minus_ls = last_trans_us_ff - last_sample_ff;
   assign br = (last_trans_us_ff > last_sample_ff) &&
               ($signed(lt_minus_ls) > $signed(now_ff - last_trans_us_ff));

   always_comb begin
      d_sel  = tpos - last_trans_pos_ff;
      dt_sel = trans_ff - last_trans_us_ff;
      case (cmd.div_sel)
         SEL_FS: begin
            d_sel  = tpos - last_trans_pos_ff;
            dt_sel = trans_ff - last_trans_us_ff;
         end
         SEL_HI: begin
            d_sel  = br ? (last_trans_pos_ff - last_low_ff) : (high - last_trans_pos_ff);
            dt_sel = br ? lt_minus_ls : (now_ff - last_trans_us_ff);
         end
         SEL_LO: begin
            d_sel  = br ? (last_trans_pos_ff - last_high_ff) : (low - last_trans_pos_ff);
            dt_sel = br ? lt_minus_ls : (now_ff - last_trans_us_ff);
         end
         default: ;
      endcase
      d_abs  = d_sel[DataWidth-1] ? (32'd0 - d_sel) : d_sel;
      dt_abs = dt_sel[DataWidth-1] ? (32'd0 - dt_sel) : dt_sel;
      if (cmd.div_sel == SEL_Q) begin
         div_num = {32'd0, mag13_ff};
         div_den = {24'd0, cpu_ff};
      end else begin
         div_num = {12'd0, d_abs, 20'd0};
         div_den = dt_abs;
      end
   end

   qse_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign qres     = dzero_ff ? 32'd0 : div_quo[DataWidth-1:0];
   assign sres     = dzero_ff ? 32'd0 :
                     (neg_ff ? (32'd0 - div_quo[DataWidth-1:0]) : div_quo[DataWidth-1:0]);
   assign trans_in = now_ff - qres;

   assign idle_in  = changed ? '0 : ((idle_ff == 8'hFF) ? idle_ff : idle_ff + 8'd1);
   assign stop_now = !stopped_ff && (idle_in >= idle_lim_ff);

   assign f1 = ($signed(fine_ff) > $signed(shi_ff)) ? shi_ff : fine_ff;
   assign f2 = ($signed(f1) < $signed(slo_ff)) ? slo_ff : f1;

   assign psec = $signed(fine_ff) * $signed(UsPerSecK);
   assign ppos = $signed(fine_ff) * $signed({1'b0, now_ff - trans_ff});

   assign pos_raw = last_trans_pos_ff + pprod_ff;
   always_comb begin
      if ($signed(pos_raw - high) > 0)      pos_in = high;
      else if ($signed(pos_raw - low) < 0)  pos_in = low;
      else                                  pos_in = pos_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff         <= 1'b0;
         stopped_ff        <= 1'b1;
         idle_ff           <= '0;
         prev_step_ff      <= '0;
         last_sample_ff    <= '0;
         last_trans_us_ff  <= '0;
         last_trans_pos_ff <= '0;
         last_low_ff       <= '0;
         last_high_ff      <= '0;
         fine_ff           <= '0;
         sec_ff            <= '0;
         pos_est_ff        <= '0;
      end else begin
         case (cmd.op)
            OP_PRIME: begin
               primed_ff        <= 1'b1;
               prev_step_ff     <= step_ff;
               last_sample_ff   <= now_ff;
               last_trans_us_ff <= trans_in;
               pos_est_ff       <= low + SubstepHalf;
            end
            OP_TRANS: begin
               idle_ff <= idle_in;
               if (stop_now) begin
                  sec_ff     <= '0;
                  fine_ff    <= '0;
                  stopped_ff <= 1'b1;
               end
            end
            OP_WR_FS: fine_ff <= sres;
            OP_TRUPD: begin
               if (changed) begin
                  stopped_ff        <= 1'b0;
                  last_trans_pos_ff <= tpos;
                  last_trans_us_ff  <= trans_ff;
               end
            end
            OP_CLAMP: fine_ff <= f2;
            OP_MUL:   sec_ff <= psec[47:16];
            OP_POS:   pos_est_ff <= pos_in;
            OP_FIN: begin
               last_low_ff    <= low;
               last_high_ff   <= high;
               prev_step_ff   <= step_ff;
               last_sample_ff <= now_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_CAPTURE) begin
         step_ff  <= req_step_count;
         now_ff   <= req_sample_us;
         fwd_ff   <= req_transition_cycles[DataWidth-1];
         mag13_ff <= mag13_in;
      end
      if (cmd.div_start) begin
         dzero_ff <= (div_den == '0);
         neg_ff   <= d_sel[DataWidth-1] ^ dt_sel[DataWidth-1];
      end
      if (cmd.op == OP_TRANS) trans_ff <= trans_in;
      if (cmd.op == OP_WR_HI) shi_ff <= sres;
      if (cmd.op == OP_WR_LO) slo_ff <= sres;
      if (cmd.op == OP_MUL)   pprod_ff <= ppos[51:20];
      // result register: none of these change in the final step
      if (cmd.op == OP_FIN || cmd.op == OP_OUTLOAD) begin
         out_pos_ff  <= pos_est_ff;
         out_sec_ff  <= sec_ff;
         out_fine_ff <= fine_ff;
         out_stop_ff <= stopped_ff;
      end
   end

   assign status = {div_done, primed_ff, changed, stopped_ff};

   assign rsp_position   = out_pos_ff;
   assign rsp_speed      = $signed(out_sec_ff);
   assign rsp_speed_fine = $signed(out_fine_ff);
   assign rsp_is_stopped = out_stop_ff;

endmodule

FILE: sv/qse_ctrl.sv
// qse_ctrl: sequencer of the estimator; issues datapath operations and divider starts.
// Depends on qse_pkg.
`timescale 1ns / 1ps
module qse_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  qse_pkg::qse_status_type status,
   output qse_pkg::qse_cmd_type    cmd
);
   import qse_pkg::*;

   qse_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in      = state_ff;
      cmd.op        = OP_NONE;
      cmd.div_start = 1'b0;
      cmd.div_sel   = SEL_Q;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_CAPTURE;
               state_in = S_QS;
            end
         end
         S_QS: begin
            cmd.div_start = 1'b1;
            state_in      = S_QW;
         end
         S_QW: begin
            if (status.div_done) begin
               if (!status.primed) begin
                  cmd.op   = OP_PRIME;
                  state_in = S_POUT;
               end else begin
                  cmd.op   = OP_TRANS;
                  state_in = S_CHK;
               end
            end
         end
         S_POUT: begin
            cmd.op   = OP_OUTLOAD;
            state_in = S_OUT;
         end
         S_CHK: state_in = (status.changed && !status.stopped) ? S_FSS : S_TR;
         S_FSS: begin
            cmd.div_sel   = SEL_FS;
            cmd.div_start = 1'b1;
            state_in      = S_FSW;
         end
         S_FSW: begin
            if (status.div_done) begin
               cmd.op   = OP_WR_FS;
               state_in = S_TR;
            end
         end
         S_TR: begin
            cmd.op   = OP_TRUPD;
            state_in = (status.changed || !status.stopped) ? S_HIS : S_FIN;
         end
         S_HIS: begin
            cmd.div_sel   = SEL_HI;
            cmd.div_start = 1'b1;
            state_in      = S_HIW;
         end
         S_HIW: begin
            if (status.div_done) begin
               cmd.op   = OP_WR_HI;
               state_in = S_LOS;
            end
         end
         S_LOS: begin
            cmd.div_sel   = SEL_LO;
            cmd.div_start = 1'b1;
            state_in      = S_LOW;
         end
         S_LOW: begin
            if (status.div_done) begin
               cmd.op   = OP_WR_LO;
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            cmd.op   = OP_CLAMP;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.op   = OP_MUL;
            state_in = S_POS;
         end
         S_POS: begin
            cmd.op   = OP_POS;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.op   = OP_FIN;
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

FILE: sv/qse_checker.sv
// qse_checker: port-level assertions for the estimator, bound to the top level.
// Depends on quadrature_substep_estimator.
`timescale 1ns / 1ps
module qse_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_position
);

   // a waiting result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position))
      else $error("result item changed while stalled");

   // one item in flight: no new item while a result is shown
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while result pending");

   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid && !req_ready)
      else $error("result or ready right after accept");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready && !rsp_valid)
      else $error("not idle after result taken");

endmodule

bind quadrature_substep_estimator qse_checker u_qse_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_position (rsp_position)
);

FILE: tb/tb_quadrature_substep_estimator.sv
// tb_quadrature_substep_estimator: self-checking regression of the sub-step estimator.
// Depends on qse_pkg and quadrature_substep_estimator; a scoreboard class predicts
// every result item from the accepted sample items.
`timescale 1ns / 1ps
module tb_quadrature_substep_estimator;
   import qse_pkg::*;

   localparam int unsigned LoopClocks  = 13;
   localparam longint      UsPerSec64  = 64'sd62500;
   localparam logic [2:0]  CsrBadIndex = 3'd5;
   localparam int unsigned CycleLimit  = 4000000;
   localparam int unsigned NumPhases   = 10;
   localparam int unsigned PhaseItems  = 145;

   typedef struct {
      logic [31:0] position;
      logic [31:0] speed;
      logic [31:0] speed_fine;
      logic        stopped;
   } estimate_type;

   class estimate_scoreboard;
      logic [7:0]  cpu, ph1, ph2, ph3, idle_lim;
      logic        primed, stopped_flag;
      logic [31:0] prev_step, last_sample_us, last_trans_us, last_trans_pos;
      logic [31:0] last_low, last_high, fine_speed, sec_speed, pos_est;
      logic [7:0]  idle_count;
      estimate_type expected_q[$];
      int unsigned mismatches;

      function new();
         cpu = RstClocksPerUs; ph1 = RstPhase1; ph2 = RstPhase2; ph3 = RstPhase3;
         idle_lim = RstIdleLimit;
         primed = 0; stopped_flag = 1; idle_count = 0;
         prev_step = 0; last_sample_us = 0; last_trans_us = 0; last_trans_pos = 0;
         last_low = 0; last_high = 0; fine_speed = 0; sec_speed = 0; pos_est = 0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [7:0] val);
         case (idx)
            CSR_CLOCKS_PER_US: cpu = val;
            CSR_PHASE1:        ph1 = val;
            CSR_PHASE2:        ph2 = val;
            CSR_PHASE3:        ph3 = val;
            CSR_IDLE_LIMIT:    idle_lim = val;
            default: ;
         endcase
      endfunction

      function logic [31:0] first_substep(logic [31:0] step);
         logic [7:0] off;
         case (step[1:0])
            2'd1: off = ph1;
            2'd2: off = ph2;
            2'd3: off = ph3;
            default: off = 8'd0;
         endcase
         return ((step << 6) & 32'hFFFF_FF00) | {24'd0, off};
      endfunction

      // (d << 20) / dt at 64 bits, toward zero, zero divisor gives 0
      function logic [31:0] slope(logic [31:0] d, logic [31:0] dt);
         longint num, den, quo;
         num = longint'($signed(d)) * 64'sd1048576;
         den = longint'($signed(dt));
         if (den == 0) return 32'd0;
         quo = num / den;
         return quo[31:0];
      endfunction

      function void note_sample(logic [31:0] step, logic [31:0] cyc, logic [31:0] now);
         logic [31:0] mag, q, trans_us, low, high, tpos, s_hi, s_lo, pos;
         logic [63:0] prod;
         logic        fwd;
         estimate_type e;
         if ($signed(cyc) < 0) begin
            mag = 32'd0 - cyc;
            fwd = 1;
         end else begin
            mag = SignBit - cyc;
            fwd = 0;
         end
         mag = mag * LoopClocks;
         q = (cpu != 0) ? mag / {24'd0, cpu} : 32'd0;
         trans_us = now - q;
         if (!primed) begin
            primed = 1;
            prev_step = step;
            last_sample_us = now;
            last_trans_us = trans_us;
            pos_est = first_substep(step) + SubstepHalf;
         end else begin
            low = first_substep(step);
            high = first_substep(step + 32'd1);
            if (step == prev_step) begin
               if (idle_count != 8'd255) idle_count++;
            end else begin
               idle_count = 0;
            end
            if (!stopped_flag && idle_count >= idle_lim) begin
               sec_speed = 0;
               fine_speed = 0;
               stopped_flag = 1;
            end
            if (step != prev_step) begin
               tpos = fwd ? low : high;
               if (!stopped_flag)
                  fine_speed = slope(tpos - last_trans_pos, trans_us - last_trans_us);
               stopped_flag = 0;
               last_trans_pos = tpos;
               last_trans_us = trans_us;
            end
            if (!stopped_flag) begin
               // transition stamp ahead of the previous sample: bound by the previous step
               if (last_trans_us > last_sample_us &&
                   $signed(last_trans_us - last_sample_us) > $signed(now - last_trans_us)) begin
                  s_hi = slope(last_trans_pos - last_low, last_trans_us - last_sample_us);
                  s_lo = slope(last_trans_pos - last_high, last_trans_us - last_sample_us);
               end else begin
                  s_hi = slope(high - last_trans_pos, now - last_trans_us);
                  s_lo = slope(low - last_trans_pos, now - last_trans_us);
               end
               if ($signed(fine_speed) > $signed(s_hi)) fine_speed = s_hi;
               if ($signed(fine_speed) < $signed(s_lo)) fine_speed = s_lo;
               prod = longint'($signed(fine_speed)) * UsPerSec64;
               sec_speed = prod[47:16];
               prod = longint'($signed(fine_speed)) * longint'({32'd0, now - trans_us});
               pos = last_trans_pos + prod[51:20];
               if ($signed(pos - high) > 0)
                  pos = high;
               else if ($signed(pos - low) < 0)
                  pos = low;
               pos_est = pos;
            end
            last_low = low;
            last_high = high;
            prev_step = step;
            last_sample_us = now;
         end
         e.position = pos_est;
         e.speed = sec_speed;
         e.speed_fine = fine_speed;
         e.stopped = stopped_flag;
         expected_q.push_back(e);
      endfunction

      function void check_result(estimate_type got);
         estimate_type e;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result item: pos %h speed %h fine %h stop %b",
                        got.position, got.speed, got.speed_fine, got.stopped);
            return;
         end
         e = expected_q.pop_front();
         if (got.position !== e.position || got.speed !== e.speed ||
             got.speed_fine !== e.speed_fine || got.stopped !== e.stopped) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp pos %h speed %h fine %h stop %b, got %h %h %h %b",
                        e.position, e.speed, e.speed_fine, e.stopped,
                        got.position, got.speed, got.speed_fine, got.stopped);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [31:0] req_step_count = 0;
   logic [31:0] req_transition_cycles = 0;
   logic [31:0] req_sample_us = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [31:0] rsp_position, rsp_speed, rsp_speed_fine;
   logic        rsp_is_stopped;
   logic        csr_we = 0;
   logic [2:0]  csr_index = 0;
   logic [7:0]  csr_wdata = 0;

   estimate_scoreboard sb = new();
   bit          idling = 1;
   bit          hold_request = 0;
   bit          rsp_hold = 0;
   int unsigned cycles = 0;
   logic [31:0] cur_step, cur_us;

   quadrature_substep_estimator dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("quadrature_substep_estimator regression: fail");
         $finish;
      end
   end

   // long receiver hold-off so the block stalls its input
   always @(posedge clock) begin
      if (hold_request && !rsp_hold) begin
         hold_request = 0;
         rsp_hold = 1;
         repeat (3000) @(posedge clock);
         rsp_hold = 0;
      end
   end

   initial begin
      int unsigned stall_left;
      estimate_type got;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got.position = rsp_position;
            got.speed = rsp_speed;
            got.speed_fine = rsp_speed_fine;
            got.stopped = rsp_is_stopped;
            sb.check_result(got);
         end
         if (stall_left == 0 && idling && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 10);
         if (rsp_hold || reset) begin
            rsp_ready <= 0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   task automatic send_sample(logic [31:0] step, logic [31:0] cyc, logic [31:0] now);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1;
      req_step_count <= step;
      req_transition_cycles <= cyc;
      req_sample_us <= now;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(step, cyc, now);
   endtask

   task automatic wait_drain();
      req_valid <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [7:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      sb.write_reg(idx, val);
   endtask

   function automatic logic [7:0] pick_reg(logic [7:0] lo);
      case ($urandom_range(0, 3))
         0: return lo;
         1: return 8'd255;
         default: return 8'($urandom_range(lo, 255));
      endcase
   endfunction

   // plausible motion with random content; some items are pure noise
   task automatic random_sample();
      int          d;
      logic [31:0] cyc;
      if ($urandom_range(0, 99) < 15) begin
         send_sample($urandom, $urandom, $urandom);
         return;
      end
      cur_us = cur_us + $urandom_range(1, 20000);
      case ($urandom_range(0, 5))
         0, 1: d = 0;
         2, 3: d = $urandom_range(1, 3);
         default: d = -$urandom_range(1, 3);
      endcase
      cur_step = cur_step + d;
      if (d > 0 || (d == 0 && $urandom_range(0, 1)))
         cyc = 32'd0 - $urandom_range(1, 60000);
      else
         cyc = SignBit - $urandom_range(1, 60000);
      send_sample(cur_step, cyc, cur_us);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: priming, idle stop, both directions, wrap and field extremes
      idling = 0;
      send_sample(32'd10, 32'hFFFF_F000, 32'd1000);
      send_sample(32'd10, 32'hFFFF_F000, 32'd2000);
      send_sample(32'd11, 32'hFFFF_FF00, 32'd3000);
      send_sample(32'd12, 32'hFFFF_FF80, 32'd4000);
      send_sample(32'd12, 32'hFFFF_FF80, 32'd5000);
      send_sample(32'd12, 32'hFFFF_FF80, 32'd6000);
      send_sample(32'd12, 32'hFFFF_FF80, 32'd7000);
      send_sample(32'd11, 32'h7FFF_FF00, 32'd8000);
      send_sample(32'd10, 32'h7FFF_FFFF, 32'd9000);
      send_sample(32'd9, 32'd0, 32'd9000);
      send_sample(32'd8, 32'h8000_0000, 32'd9000);
      send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_sample(32'd0, 32'hFFFF_FFFE, 32'd0);
      send_sample(32'd1, 32'hFFFF_FFF0, 32'd0);
      wait_drain();
      write_reg(CSR_CLOCKS_PER_US, 8'd0);
      write_reg(CSR_IDLE_LIMIT, 8'd0);
      write_reg(CsrBadIndex, 8'hA5);
      send_sample(32'd2, 32'hFFFF_0000, 32'd500);
      send_sample(32'd2, 32'hFFFF_0000, 32'd600);
      send_sample(32'd3, 32'hFFFF_8000, 32'd700);
      wait_drain();
      write_reg(CSR_CLOCKS_PER_US, 8'd255);
      write_reg(CSR_PHASE1, 8'd0);
      write_reg(CSR_PHASE2, 8'd255);
      write_reg(CSR_PHASE3, 8'd0);
      write_reg(CSR_IDLE_LIMIT, 8'd255);
      send_sample(32'd4, 32'hFFFF_0000, 32'd800);
      send_sample(32'd5, 32'hFFFF_0000, 32'd900);
      send_sample(32'd6, 32'hFFFF_0000, 32'd950);
      wait_drain();

      cur_step = $urandom;
      cur_us = $urandom;
      for (int p = 0; p < NumPhases; p++) begin
         idling = (p < NumPhases - 2);
         write_reg(CSR_CLOCKS_PER_US, pick_reg(8'd1));
         write_reg(CSR_PHASE1, pick_reg(8'd0));
         write_reg(CSR_PHASE2, pick_reg(8'd0));
         write_reg(CSR_PHASE3, pick_reg(8'd0));
         write_reg(CSR_IDLE_LIMIT, (p == 0) ? RstIdleLimit : pick_reg(8'd0));
         for (int i = 0; i < PhaseItems; i++) begin
            if (p == 1 && i == 20) hold_request = 1;
            random_sample();
         end
         wait_drain();
      end

      repeat (400) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0)
         $display("quadrature_substep_estimator regression: pass");
      else
         $display("quadrature_substep_estimator regression: fail");
      $finish;
   end

endmodule

FILE: quadrature_substep_estimator.f
sv/qse_pkg.sv
sv/qse_div.sv
sv/qse_dp.sv
sv/qse_ctrl.sv
sv/quadrature_substep_estimator.sv
sv/qse_checker.sv
tb/tb_quadrature_substep_estimator.sv
